FILE: rtl/core/bpl_pkg.sv
package bpl_pkg;

  localparam int unsigned POINTS         = 1024;
  localparam int unsigned MEASURE_LEVELS = 256;

  localparam int unsigned MEAS_W  = $clog2(MEASURE_LEVELS);
  localparam int unsigned POINT_W = $clog2(POINTS);

  // two-level priority search over the bucket bitmap
  localparam int unsigned GROUP_W = 16;
  localparam int unsigned GROUPS  = MEASURE_LEVELS / GROUP_W;
  localparam int unsigned LOW_IW  = $clog2(GROUP_W);
  localparam int unsigned GRP_IW  = MEAS_W - LOW_IW;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USED_W = MEAS_W + POINT_W + 2;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic group;
    logic level;
    logic fetch;
    logic load_out;
  } bpl_cmd_t;

endpackage

FILE: rtl/core/bpl_ctrl.sv
module bpl_ctrl
  import bpl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bpl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_GROUP,
    S_LEVEL,
    S_FETCH,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.group    = (state_q == S_GROUP);
    cmd_o.level    = (state_q == S_LEVEL);
    cmd_o.fetch    = (state_q == S_FETCH) || (state_q == S_DONE);
    cmd_o.load_out = (state_q == S_DONE) && out_free;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: state_q <= S_GROUP;
        S_GROUP:  state_q <= S_LEVEL;
        S_LEVEL:  state_q <= S_FETCH;
        S_FETCH:  state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bpl_datapath.sv
module bpl_datapath
  import bpl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpl_cmd_t              cmd_i,
  input  logic                  func_i,
  input  logic [MEAS_W-1:0]     measure_i,
  input  logic [POINT_W-1:0]    point_index_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  function automatic logic [LOW_IW-1:0] prio_hi(input logic [GROUP_W-1:0] v);
    logic [LOW_IW-1:0] r;
    r = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      if (v[i]) begin
        r = i[LOW_IW-1:0];
      end
    end
    return r;
  endfunction

  // link stores
  logic [POINT_W-1:0] first_mem [MEASURE_LEVELS];
  logic [POINT_W-1:0] last_mem  [MEASURE_LEVELS];
  logic [POINT_W-1:0] next_mem  [POINTS];
  logic [POINT_W-1:0] prev_mem  [POINTS];

  logic [POINT_W-1:0] first_rd_q, last_rd_q, next_rd_q, prev_rd_q;
  logic [MEAS_W-1:0]  first_raddr;

  logic               first_we, last_we, next_we, prev_we;
  logic [POINT_W-1:0] first_wdata, last_wdata, next_wdata, prev_wdata;
  logic [POINT_W-1:0] next_waddr, prev_waddr;

  logic                      func_q;
  logic [MEAS_W-1:0]         meas_q;
  logic [POINT_W-1:0]        pnt_q;
  logic [MEASURE_LEVELS-1:0] ne_q, ne_d;
  logic                      nf_q;
  logic                      hit, at_head, at_tail;

  logic [GROUPS-1:0]  grp_any;
  logic [GRP_IW-1:0]  grp_q;
  logic               any_q;
  logic [MEAS_W-1:0]  top_q;
  logic [MEAS_W-1:0]  grp_base;
  logic [GROUP_W-1:0] grp_bits;

  logic [OUT_DATA_W-1:0] out_data_q;

  assign first_raddr = cmd_i.fetch ? top_q : measure_i;

  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_mem[meas_q] <= first_wdata;
    end
    first_rd_q <= first_mem[first_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (last_we) begin
      last_mem[meas_q] <= last_wdata;
    end
    last_rd_q <= last_mem[measure_i];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_q <= next_mem[point_index_i];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd_q <= prev_mem[point_index_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      meas_q <= measure_i;
      pnt_q  <= point_index_i;
    end
  end

  // list update from the entries read at accept
  assign hit     = ne_q[meas_q];
  assign at_head = (first_rd_q == pnt_q);
  assign at_tail = (last_rd_q == pnt_q);

  always_comb begin
    ne_d        = ne_q;
    first_we    = 1'b0;
    last_we     = 1'b0;
    next_we     = 1'b0;
    prev_we     = 1'b0;
    first_wdata = pnt_q;
    last_wdata  = pnt_q;
    next_wdata  = pnt_q;
    prev_wdata  = last_rd_q;
    next_waddr  = last_rd_q;
    prev_waddr  = pnt_q;
    if (cmd_i.update) begin
      if (func_q == FUNC_INSERT) begin
        last_we = 1'b1;
        if (!hit) begin
          ne_d[meas_q] = 1'b1;
          first_we     = 1'b1;
        end else begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
      end else if (hit) begin
        if (at_head && at_tail) begin
          ne_d[meas_q] = 1'b0;
        end else if (at_head) begin
          first_we    = 1'b1;
          first_wdata = next_rd_q;
        end else if (at_tail) begin
          last_we    = 1'b1;
          last_wdata = prev_rd_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_rd_q;
          next_wdata = next_rd_q;
          prev_we    = 1'b1;
          prev_waddr = next_rd_q;
          prev_wdata = prev_rd_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= '0;
    end else if (cmd_i.update) begin
      ne_q <= ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      nf_q <= (func_q == FUNC_REMOVE) && !hit;
    end
  end

  // highest nonempty bucket: group first, then level inside the group
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |ne_q[g*GROUP_W +: GROUP_W];
    end
  end

  assign grp_base = {grp_q, {LOW_IW{1'b0}}};
  assign grp_bits = ne_q[grp_base +: GROUP_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.group) begin
      grp_q <= prio_hi(grp_any);
      any_q <= |grp_any;
    end
    if (cmd_i.level) begin
      top_q <= {grp_q, prio_hi(grp_bits)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                     nf_q,
                     !any_q,
                     (any_q ? first_rd_q : {POINT_W{1'b0}}),
                     (any_q ? top_q : {MEAS_W{1'b0}})};
    end
  end

  assign out_data_o = out_data_q;

endmodule

FILE: rtl/core/bucket_priority_list.sv
// steps per item: link memory read at accept, list update, two-level bitmap
//   search (group, then level), bucket head read through the link memories,
//   result load; a new item is accepted only after the last one finished them
// a result waiting on m_axis_tready holds the block in its last step only
// reset: asynchronous, clears the bucket bitmap and handshake state at once,
//   link memories are not cleared and no clearing pass is needed
module bucket_priority_list
  import bpl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // measure, point_index
  input  logic                  s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // top_measure, top_point, all_empty, not_found
);

  bpl_cmd_t cmd;

  bpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bpl_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (s_axis_tuser),
    .measure_i     (s_axis_tdata[MEAS_W-1:0]),
    .point_index_i (s_axis_tdata[MEAS_W+POINT_W-1:MEAS_W]),
    .out_data_o    (m_axis_tdata)
  );

endmodule
